[sv/mst_pkg.sv]
// mst_pkg: shared types, field widths and command/status codes for the
// MVCC snapshot tracker. No dependencies.
package mst_pkg;

    localparam int SEQ_W      = 64;
    localparam int HANDLE_W   = 32;
    localparam int ACT_W      = 5;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;

    localparam int MAX_ACTIVE_DEF = 16;

    typedef logic [SEQ_W-1:0]    seq_t;
    typedef logic [HANDLE_W-1:0] handle_t;
    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [ACT_W-1:0]    act_t;

    // one table entry: snapshot sequence and its handle
    typedef struct packed {
        seq_t    seq;
        handle_t handle;
    } entry_t;

    localparam cmd_t CMD_ALLOC   = 2'd0;
    localparam cmd_t CMD_CREATE  = 2'd1;
    localparam cmd_t CMD_RELEASE = 2'd2;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_FULL      = 2'd1;
    localparam status_t ST_NOT_FOUND = 2'd2;

    localparam seq_t SEQ_ALL_ONES = '1;
    localparam seq_t SEQ_ONE      = 64'd1;

endpackage

[sv/mvcc_snapshot_tracker.sv]
// mvcc_snapshot_tracker: MVCC snapshot table with sequence allocation,
// create and release-with-compaction. Depends on mst_pkg.
//
// Command channel (cmd_valid/cmd_ready) carries cmd and release_handle; the
// response channel (rsp_valid/rsp_ready) returns one beat per command with
// status, seq_out, handle_out, oldest_seq, active_count and both totals.
// Commands run one at a time. Allocate, create and unused codes finish in the
// execute state; a release goes on to scan the live entries, so its time
// grows with the live count.
// Release time is set by the table memory: one read port walks the live
// entries, comparing handles and folding the minimum sequence, while each
// entry after the released one is written back one slot lower, always
// below the next read address, so no forwarding is needed.
// A new command is taken while the previous response still waits; it
// completes only once the receiver has taken that response.
// Reset: sequence counter = 1, table empty, oldest = all ones, totals 0.
// Table memory is not cleared; only entries below the live count are read.
module mvcc_snapshot_tracker
#(
    parameter int MAX_ACTIVE = mst_pkg::MAX_ACTIVE_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  mst_pkg::cmd_t      cmd,
    input  mst_pkg::handle_t   release_handle,

    output logic               rsp_valid,
    input  logic               rsp_ready,
    output mst_pkg::status_t   status,
    output mst_pkg::seq_t      seq_out,
    output mst_pkg::handle_t   handle_out,
    output mst_pkg::seq_t      oldest_seq,
    output mst_pkg::act_t      active_count,
    output mst_pkg::seq_t      created_total,
    output mst_pkg::seq_t      released_total
);
    import mst_pkg::*;

    localparam int IDX_W = (MAX_ACTIVE > 1) ? $clog2(MAX_ACTIVE) : 1;
    localparam int CNT_W = $clog2(MAX_ACTIVE + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ACTIVE);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    // snapshot table
    entry_t mem [MAX_ACTIVE];

    logic [1:0]       state_reg, state_next;
    cmd_t             cmd_reg;
    handle_t          handle_reg;

    seq_t             next_seq_reg, next_seq_next;
    logic [CNT_W-1:0] live_reg, live_next;
    seq_t             oldest_reg, oldest_next;
    seq_t             create_reg, create_next;
    seq_t             release_reg, release_next;

    // release scan
    logic [CNT_W-1:0] iss_reg, iss_next;
    logic             found_reg, found_next;
    seq_t             min_reg, min_next;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    entry_t           rd_data_reg;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;

    // response register
    logic             rsp_valid_reg, rsp_valid_next;
    status_t          status_reg, status_next;
    seq_t             seq_out_reg, seq_out_next;
    handle_t          handle_out_reg, handle_out_next;
    seq_t             oldest_out_reg, oldest_out_next;
    act_t             act_out_reg, act_out_next;
    seq_t             created_out_reg, created_out_next;
    seq_t             released_out_reg, released_out_next;

    logic             rsp_free;
    logic             load;
    logic             hit;
    logic             scan_done;

    assign cmd_ready = (state_reg == S_IDLE);
    assign rsp_free  = !rsp_valid_reg || rsp_ready;

    assign rd_en     = (state_reg == S_SCAN) && (iss_reg != live_reg);
    assign rd_addr   = iss_reg[IDX_W-1:0];
    assign hit       = rd_vld_reg && !found_reg && (rd_data_reg.handle == handle_reg);
    assign scan_done = (state_reg == S_SCAN) && (iss_reg == live_reg) && !rd_vld_reg;

    always_comb
    begin
        state_next        = state_reg;
        next_seq_next     = next_seq_reg;
        live_next         = live_reg;
        oldest_next       = oldest_reg;
        create_next       = create_reg;
        release_next      = release_reg;
        iss_next          = iss_reg;
        found_next        = found_reg;
        min_next          = min_reg;
        wr_en             = 1'b0;
        wr_addr           = live_reg[IDX_W-1:0];
        wr_data           = rd_data_reg;
        load              = 1'b0;
        status_next       = ST_OK;
        seq_out_next      = '0;
        handle_out_next   = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (cmd_reg == CMD_RELEASE)
                begin
                    iss_next   = '0;
                    found_next = 1'b0;
                    min_next   = SEQ_ALL_ONES;
                    state_next = S_SCAN;
                end
                else if (rsp_free)
                begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                    if (cmd_reg == CMD_ALLOC)
                    begin
                        seq_out_next  = next_seq_reg;
                        next_seq_next = next_seq_reg + SEQ_ONE;
                    end
                    else if (cmd_reg == CMD_CREATE)
                    begin
                        if (live_reg >= CNT_MAX)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            seq_out_next    = next_seq_reg;
                            handle_out_next = create_reg[HANDLE_W-1:0];
                            wr_en           = 1'b1;
                            wr_addr         = live_reg[IDX_W-1:0];
                            wr_data.seq     = next_seq_reg;
                            wr_data.handle  = create_reg[HANDLE_W-1:0];
                            live_next       = live_reg + CNT_ONE;
                            create_next     = create_reg + SEQ_ONE;
                            if (next_seq_reg < oldest_reg)
                            begin
                                oldest_next = next_seq_reg;
                            end
                        end
                    end
                end
            end
            S_SCAN:
            begin
                if (rd_en)
                begin
                    iss_next = iss_reg + CNT_ONE;
                end
                if (rd_vld_reg)
                begin
                    // entries past the released one move down a slot
                    if (found_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = rd_idx_reg - IDX_W'(1);
                    end
                    if (hit)
                    begin
                        found_next = 1'b1;
                    end
                    else if (rd_data_reg.seq < min_reg)
                    begin
                        min_next = rd_data_reg.seq;
                    end
                end
                if (scan_done && rsp_free)
                begin
                    load         = 1'b1;
                    state_next   = S_IDLE;
                    status_next  = found_reg ? ST_OK : ST_NOT_FOUND;
                    live_next    = live_reg - (found_reg ? CNT_ONE : '0);
                    oldest_next  = min_reg;
                    release_next = release_reg + SEQ_ONE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next    = load ? 1'b1 : (rsp_valid_reg && !rsp_ready);
        oldest_out_next   = oldest_next;
        act_out_next      = ACT_W'(live_next);
        created_out_next  = create_next;
        released_out_next = release_next;
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            next_seq_reg  <= SEQ_ONE;
            live_reg      <= '0;
            oldest_reg    <= SEQ_ALL_ONES;
            create_reg    <= '0;
            release_reg   <= '0;
            iss_reg       <= '0;
            found_reg     <= 1'b0;
            rd_vld_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            next_seq_reg  <= next_seq_next;
            live_reg      <= live_next;
            oldest_reg    <= oldest_next;
            create_reg    <= create_next;
            release_reg   <= release_next;
            iss_reg       <= iss_next;
            found_reg     <= found_next;
            rd_vld_reg    <= rd_en;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            cmd_reg    <= cmd;
            handle_reg <= release_handle;
        end
        min_reg    <= min_next;
        rd_idx_reg <= rd_addr;
        if (load)
        begin
            status_reg       <= status_next;
            seq_out_reg      <= seq_out_next;
            handle_out_reg   <= handle_out_next;
            oldest_out_reg   <= oldest_out_next;
            act_out_reg      <= act_out_next;
            created_out_reg  <= created_out_next;
            released_out_reg <= released_out_next;
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign status         = status_reg;
    assign seq_out        = seq_out_reg;
    assign handle_out     = handle_out_reg;
    assign oldest_seq     = oldest_out_reg;
    assign active_count   = act_out_reg;
    assign created_total  = created_out_reg;
    assign released_total = released_out_reg;

    // table never overfills
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= CNT_MAX)
        else $error("live count above table size");

    // empty table reports no oldest snapshot
    a_empty_oldest: assert property (@(posedge clk) disable iff (!rst_n)
        (live_reg == '0) |-> (oldest_reg == SEQ_ALL_ONES))
        else $error("empty table with oldest sequence set");

    // scan reads never outlive the scan state
    a_scan_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !rd_vld_reg)
        else $error("table read pending while idle");

    // compaction writes only follow a handle match
    a_shift_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SCAN) && wr_en) |-> found_reg)
        else $error("table shift without a released entry");

endmodule

[verif/mvcc_snapshot_tracker_test.sv]
// mvcc_snapshot_tracker_test: self-checking testbench for the MVCC snapshot tracker.
// It runs directed and random command streams against an in-bench table predictor.
// Depends on mst_pkg and mvcc_snapshot_tracker.
module mvcc_snapshot_tracker_test;

    timeunit 1ns;
    timeprecision 1ps;

    import mst_pkg::*;

    localparam int   MAX_ACTIVE = MAX_ACTIVE_DEF;
    localparam cmd_t CMD_UNUSED = 2'd3;     // undefined opcode, must be a no-op
    localparam int   STALL_LIMIT = 3000;    // cycles without any beat before giving up
    localparam int   DRAIN_CYCLES = 40;     // longer than the worst release on a full table

    // one expected response beat, tagged with the command that caused it
    typedef struct packed {
        cmd_t    op;
        status_t status;
        seq_t    seq;
        handle_t handle;
        seq_t    oldest;
        act_t    count;
        seq_t    created;
        seq_t    released;
    } snap_rsp_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;

    logic    cmd_valid = 1'b0;
    logic    cmd_ready;
    cmd_t    cmd = CMD_ALLOC;
    handle_t release_handle = '0;

    logic    rsp_valid;
    logic    rsp_ready = 1'b0;
    status_t status;
    seq_t    seq_out;
    handle_t handle_out;
    seq_t    oldest_seq;
    act_t    active_count;
    seq_t    created_total;
    seq_t    released_total;

    // predicted block state
    seq_t    next_seq_pred;
    seq_t    snap_seq [MAX_ACTIVE];
    handle_t snap_handle [MAX_ACTIVE];
    int      live_cnt;
    seq_t    oldest_pred;
    seq_t    creates_seen;
    seq_t    releases_seen;

    snap_rsp_t pending_rsp [$];   // expected beats, oldest first
    int      errors = 0;
    bit      tx_gaps_on = 1'b1;   // sender idles in bursts
    bit      rx_stall_on = 1'b1;  // receiver stalls in bursts
    int      rx_hold = 0;
    int      quiet_cycles = 0;

    mvcc_snapshot_tracker #(
        .MAX_ACTIVE(MAX_ACTIVE)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .cmd            (cmd),
        .release_handle (release_handle),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .status         (status),
        .seq_out        (seq_out),
        .handle_out     (handle_out),
        .oldest_seq     (oldest_seq),
        .active_count   (active_count),
        .created_total  (created_total),
        .released_total (released_total)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $time, what);
        errors++;
    endtask

    task automatic check_field(input string name, input cmd_t op,
                               input logic [63:0] got, input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("cmd %0d %s: got %h, want %h", op, name, got, want));
    endtask

    // Table predictor. Applies one command to the predicted state and returns
    // the beat the block must answer with.
    task automatic apply_snapshot_cmd(input cmd_t op, input handle_t h, output snap_rsp_t r);
        int hit;
        r = '0;
        r.op = op;
        hit = -1;
        case (op)
            CMD_ALLOC:
            begin
                r.seq = next_seq_pred;
                next_seq_pred = next_seq_pred + 1;
            end
            CMD_CREATE:
            begin
                if (live_cnt >= MAX_ACTIVE)
                    r.status = ST_FULL;
                else
                begin
                    // handle is the create count before this create
                    r.seq = next_seq_pred;
                    r.handle = creates_seen[HANDLE_W-1:0];
                    snap_seq[live_cnt] = next_seq_pred;
                    snap_handle[live_cnt] = r.handle;
                    live_cnt++;
                    creates_seen = creates_seen + 1;
                    if (next_seq_pred < oldest_pred)
                        oldest_pred = next_seq_pred;
                end
            end
            CMD_RELEASE:
            begin
                // first match wins, later entries move down one slot
                for (int i = 0; i < live_cnt; i++)
                    if (hit < 0 && snap_handle[i] == h)
                        hit = i;
                if (hit >= 0)
                begin
                    for (int i = hit; i < live_cnt - 1; i++)
                    begin
                        snap_seq[i] = snap_seq[i + 1];
                        snap_handle[i] = snap_handle[i + 1];
                    end
                    live_cnt--;
                end
                else
                    r.status = ST_NOT_FOUND;
                // counted even when the handle is unknown
                releases_seen = releases_seen + 1;
                oldest_pred = SEQ_ALL_ONES;
                for (int i = 0; i < live_cnt; i++)
                    if (snap_seq[i] < oldest_pred)
                        oldest_pred = snap_seq[i];
            end
            default: ;
        endcase
        r.oldest = oldest_pred;
        r.count = act_t'(live_cnt);
        r.created = creates_seen;
        r.released = releases_seen;
    endtask

    // Drive one command beat and hold it until taken. Called right after a
    // rising edge; leaves the bench right after the accepting edge, optionally
    // followed by an idle burst.
    task automatic send_cmd(input cmd_t op, input handle_t h);
        snap_rsp_t exp_rsp;
        cmd_valid <= 1'b1;
        cmd <= op;
        release_handle <= h;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        apply_snapshot_cmd(op, h, exp_rsp);
        pending_rsp.push_back(exp_rsp);
        if (tx_gaps_on && $urandom_range(0, 3) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 9))
                @(posedge clk);
        end
    endtask

    // Hold the sender off until every outstanding response has returned.
    task automatic wait_rsp_drained();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: rsp_ready drops in random bursts while stalls are on.
    always @(posedge clk)
    begin
        if (rx_hold > 0)
        begin
            rsp_ready <= 1'b0;
            rx_hold = rx_hold - 1;
        end
        else if (rx_stall_on && $urandom_range(0, 4) == 0)
        begin
            rsp_ready <= 1'b0;
            rx_hold = $urandom_range(1, 9) - 1;
        end
        else
            rsp_ready <= 1'b1;
    end

    // Response checker: every accepted beat is matched against the oldest
    // expectation, field by field.
    always @(posedge clk)
    begin
        snap_rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
                report_mismatch("response beat with no command outstanding");
            else
            begin
                want = pending_rsp.pop_front();
                check_field("status", want.op, 64'(status), 64'(want.status));
                check_field("seq_out", want.op, seq_out, want.seq);
                check_field("handle_out", want.op, 64'(handle_out), 64'(want.handle));
                check_field("oldest_seq", want.op, oldest_seq, want.oldest);
                check_field("active_count", want.op, 64'(active_count), 64'(want.count));
                check_field("created_total", want.op, created_total, want.created);
                check_field("released_total", want.op, released_total, want.released);
            end
        end
    end

    // Watchdog: any beat on either channel resets the count.
    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("ERROR @%0t: no handshake for %0d cycles, %0d responses outstanding",
                     $time, STALL_LIMIT, pending_rsp.size());
            $display("mvcc_snapshot_tracker regression: fail");
            $finish;
        end
    end

    // Empty table: unused opcode must be a no-op; release on an empty table
    // misses but still bumps the release total.
    task automatic test_empty_table();
        send_cmd(CMD_UNUSED, 32'h5A5A_A5A5);
        send_cmd(CMD_RELEASE, 32'hFFFF_FFFF);
    endtask

    // Allocation moves the counter, create snapshots it without moving it.
    task automatic test_alloc_create();
        send_cmd(CMD_ALLOC, '0);
        send_cmd(CMD_CREATE, '1);
        send_cmd(CMD_ALLOC, '0);
        send_cmd(CMD_CREATE, '0);
    endtask

    // Fill the table to capacity, then one more create must report full.
    task automatic test_table_full();
        while (live_cnt < MAX_ACTIVE)
            send_cmd(CMD_CREATE, $urandom());
        send_cmd(CMD_CREATE, $urandom());
    endtask

    // Release the oldest entry (oldest_seq must move), one from the middle,
    // and the last one (no compaction needed).
    task automatic test_release_order();
        send_cmd(CMD_RELEASE, snap_handle[0]);
        send_cmd(CMD_RELEASE, snap_handle[live_cnt / 2]);
        send_cmd(CMD_RELEASE, snap_handle[live_cnt - 1]);
    endtask

    // Random mix in segments. Each segment picks its own create bias so the
    // table swings between empty and full, and its own idling on both sides.
    // Most releases hit a live handle; the rest carry random 32-bit handles.
    task automatic test_random_mix(input int n_items);
        int seg;
        int create_pct;
        int pick;
        for (int k = 0; k < n_items; k++)
        begin
            if (k % 50 == 0)
            begin
                seg = k / 50;
                if (seg % 4 == 3)
                    wait_rsp_drained();
                create_pct = $urandom_range(10, 55);
                tx_gaps_on = ($urandom_range(0, 2) != 0);
                rx_stall_on = ($urandom_range(0, 2) != 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 20)
                send_cmd(CMD_ALLOC, $urandom());
            else if (pick < 20 + create_pct)
                send_cmd(CMD_CREATE, $urandom());
            else if (pick < 92 && live_cnt > 0)
                send_cmd(CMD_RELEASE, snap_handle[$urandom_range(0, live_cnt - 1)]);
            else if (pick < 96)
                send_cmd(CMD_RELEASE, $urandom());
            else
                send_cmd(CMD_UNUSED, $urandom());
        end
    endtask

    // Closing stretch at full rate: no idling on either side.
    task automatic test_back_to_back(input int n_items);
        int pick;
        tx_gaps_on = 1'b0;
        rx_stall_on = 1'b0;
        for (int k = 0; k < n_items; k++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
                send_cmd(CMD_ALLOC, $urandom());
            else if (pick < 6)
                send_cmd(CMD_CREATE, $urandom());
            else if (live_cnt > 0 && pick < 9)
                send_cmd(CMD_RELEASE, snap_handle[$urandom_range(0, live_cnt - 1)]);
            else
                send_cmd(CMD_RELEASE, $urandom());
        end
    endtask

    initial
    begin
        next_seq_pred = SEQ_ONE;
        live_cnt = 0;
        oldest_pred = SEQ_ALL_ONES;
        creates_seen = '0;
        releases_seen = '0;

        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_alloc_create();
        test_table_full();
        test_release_order();
        test_random_mix(830);
        test_back_to_back(100);

        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending_rsp.size() != 0)
            @(posedge clk);
        // catch any stray beat after the last expected one
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (errors == 0)
            $display("mvcc_snapshot_tracker regression: pass");
        else
            $display("mvcc_snapshot_tracker regression: fail");
        $finish;
    end

endmodule
